/* design/rfvc_pkg.sv */
// Package: sizes, request and status codes and the node record for the forest classifier.
`timescale 1ns / 1ps
`default_nettype none
package rfvc_pkg;
	localparam int MAX_NODES = 1024;
	localparam int MAX_TREES = 64;
	localparam int MAX_FEATURES = 64;
	localparam int MAX_CLASSES = 16;
	localparam int NODE_W = $clog2(MAX_NODES);
	localparam int TREE_W = $clog2(MAX_TREES);
	localparam int FEAT_W = $clog2(MAX_FEATURES);
	localparam int CLS_W = $clog2(MAX_CLASSES);
	localparam int NODE_REC_W = 1 + 6 + 32 + 10 + 10 + 4;

	localparam logic [1:0] REQ_NODE = 2'd0;
	localparam logic [1:0] REQ_ROOT = 2'd1;
	localparam logic [1:0] REQ_FEAT = 2'd2;
	localparam logic [1:0] REQ_RUN = 2'd3;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_ROOT = 3'd1;
	localparam logic [2:0] ST_CHILD = 3'd2;
	localparam logic [2:0] ST_FEAT = 3'd3;
	localparam logic [2:0] ST_CLASS = 3'd4;
	localparam logic [2:0] ST_LOOP = 3'd5;

	localparam logic [1:0] CFG_TREES = 2'd0;
	localparam logic [1:0] CFG_CLASSES = 2'd1;
	localparam logic [1:0] CFG_NODES = 2'd2;
	localparam logic [1:0] CFG_FEATS = 2'd3;

	typedef struct packed {
		logic        leaf;
		logic [5:0]  feat;
		logic [31:0] thr;
		logic [9:0]  left;
		logic [9:0]  right;
		logic [3:0]  cls;
	} node_t;
endpackage
`default_nettype wire

/* design/rfvc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module rfvc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* design/random_forest_vote_classifier_core.sv */
// Top level: random forest vote classifier with table loads and a sequenced tree walk.
//
// Usage. Items come in on start/busy: an item is taken at a clock edge with start high
// and busy low. Request 0 writes a node, 1 a tree root, 2 a feature value; each
// gives no result and leaves busy low, so writes can follow back to back. Request 3
// runs a prediction and raises busy from the next cycle. Each tree takes a root read
// (S_ROOT, S_ROOTW), a node read of its leaf, and per inner node on its path a node
// read, feature read and compare (S_NODE, S_FEAT, S_CMP), all through single read ports.
// After the last tree, state S_ROOT starts scoring: each class goes through a shared
// shift-subtract divider (a load, 23 quotient-bit steps, an emit). Busy stays high
// through the walk and the scoring; a class result is valid for one cycle, marked by
// res_valid, and the final one, with last set, is out in the first cycle with busy low.
// An error ends the walk: the state passes through S_ERR, then busy falls and one
// status result with last set is out in the first cycle with busy low.
// Configuration: cfg_valid/cfg_ready write register cfg_index with cfg_data; ready
// is held high. Reset clears control state and sets the registers to their reset
// values; table contents are undefined until written. The receiver cannot stall: a
// result is presented for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none
module random_forest_vote_classifier_core
	import rfvc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  req_type,
	input  wire logic [9:0]  slot,
	input  wire logic        node_is_leaf,
	input  wire logic [5:0]  node_feature,
	input  wire logic signed [31:0] sample_value,
	input  wire logic [9:0]  left_child,
	input  wire logic [9:0]  right_child,
	input  wire logic [3:0]  leaf_class,
	input  wire logic [9:0]  tree_root,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [10:0] cfg_data,
	output logic             res_valid,
	output logic [3:0]       class_index,
	output logic [6:0]       vote_count,
	output logic [16:0]      score_q16,
	output logic [2:0]       status,
	output logic             last
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_ROOT = 4'd1;
	localparam logic [3:0] S_ROOTW = 4'd2;
	localparam logic [3:0] S_NODE = 4'd3;
	localparam logic [3:0] S_FEAT = 4'd4;
	localparam logic [3:0] S_CMP = 4'd5;
	localparam logic [3:0] S_DIV = 4'd6;
	localparam logic [3:0] S_ERR = 4'd8;

	logic [3:0] state_q;
	logic [6:0] trees_cfg_q;
	logic [4:0] classes_cfg_q;
	logic [10:0] nodes_cfg_q;
	logic [6:0] feats_cfg_q;
	logic [6:0] trees_q;
	logic [4:0] classes_q;
	logic [10:0] nodes_q;
	logic [6:0] feats_q;
	logic [6:0] tree_q;
	logic [NODE_W-1:0] idx_q;
	logic [10:0] steps_q;
	logic [6:0] votes_q [MAX_CLASSES];
	logic [2:0] err_q;
	logic [CLS_W-1:0] cls_q;
	logic [22:0] dvd_q;
	logic [6:0] rem_q;
	logic [16:0] quo_q;
	logic [4:0] bit_q;
	node_t node_q;

	logic acc;
	logic node_we, root_we, feat_we;
	node_t node_wd, node_rd;
	logic [9:0] root_rd;
	logic [31:0] feat_rd;
	logic [NODE_W-1:0] node_ra;
	logic [TREE_W-1:0] root_ra;
	logic [FEAT_W-1:0] feat_ra;
	logic go_left;
	logic [9:0] next_idx;
	logic [7:0] rem_sh;

	assign acc = start && !busy;
	assign busy = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign node_we = acc && req_type == REQ_NODE;
	assign root_we = acc && req_type == REQ_ROOT && slot < 10'(MAX_TREES);
	assign feat_we = acc && req_type == REQ_FEAT && slot < 10'(MAX_FEATURES);
	assign node_wd = '{node_is_leaf, node_feature, sample_value, left_child, right_child,
		leaf_class};
	assign node_ra = (state_q == S_ROOTW) ? root_rd : (state_q == S_CMP) ? next_idx : idx_q;
	assign root_ra = tree_q[TREE_W-1:0];
	assign feat_ra = node_q.feat;
	assign go_left = $signed(feat_rd) <= $signed(node_q.thr);
	assign next_idx = go_left ? node_q.left : node_q.right;
	assign rem_sh = {rem_q, dvd_q[22]};

	rfvc_ram #(.WIDTH(NODE_REC_W), .DEPTH(MAX_NODES)) u_nodes (.clk(clk), .we(node_we),
		.waddr(slot[NODE_W-1:0]), .wdata(node_wd), .raddr(node_ra), .rdata(node_rd));
	rfvc_ram #(.WIDTH(10), .DEPTH(MAX_TREES)) u_roots (.clk(clk), .we(root_we),
		.waddr(slot[TREE_W-1:0]), .wdata(tree_root), .raddr(root_ra), .rdata(root_rd));
	rfvc_ram #(.WIDTH(32), .DEPTH(MAX_FEATURES)) u_feats (.clk(clk), .we(feat_we),
		.waddr(slot[FEAT_W-1:0]), .wdata(sample_value), .raddr(feat_ra), .rdata(feat_rd));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			trees_cfg_q <= 7'd1;
			classes_cfg_q <= 5'd2;
			nodes_cfg_q <= 11'd1;
			feats_cfg_q <= 7'd1;
			res_valid <= 1'b0;
			trees_q <= '0;
			classes_q <= '0;
			nodes_q <= '0;
			feats_q <= '0;
			tree_q <= '0;
			idx_q <= '0;
			steps_q <= '0;
			for (int i = 0; i < MAX_CLASSES; i++) votes_q[i] <= '0;
			err_q <= ST_OK;
			cls_q <= '0;
			dvd_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
			bit_q <= '0;
			node_q <= '0;
			class_index <= '0;
			vote_count <= '0;
			score_q16 <= '0;
			status <= ST_OK;
			last <= 1'b0;
		end else begin
			res_valid <= 1'b0;
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_TREES: trees_cfg_q <= cfg_data[6:0];
					CFG_CLASSES: classes_cfg_q <= cfg_data[4:0];
					CFG_NODES: nodes_cfg_q <= cfg_data;
					CFG_FEATS: feats_cfg_q <= cfg_data[6:0];
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc && req_type == REQ_RUN) begin
						trees_q <= (trees_cfg_q > 7'(MAX_TREES)) ? 7'(MAX_TREES) : trees_cfg_q;
						classes_q <= (classes_cfg_q > 5'(MAX_CLASSES)) ? 5'(MAX_CLASSES)
							: classes_cfg_q;
						nodes_q <= (nodes_cfg_q > 11'(MAX_NODES)) ? 11'(MAX_NODES) : nodes_cfg_q;
						feats_q <= (feats_cfg_q > 7'(MAX_FEATURES)) ? 7'(MAX_FEATURES)
							: feats_cfg_q;
						tree_q <= '0;
						for (int i = 0; i < MAX_CLASSES; i++) votes_q[i] <= '0;
						if (trees_cfg_q == '0) begin
							err_q <= ST_ROOT;
							state_q <= S_ERR;
						end else if (classes_cfg_q == '0) begin
							err_q <= ST_CLASS;
							state_q <= S_ERR;
						end else begin
							state_q <= S_ROOT;
						end
					end
				end
				S_ROOT: begin
					if (tree_q == trees_q) begin
						cls_q <= '0;
						bit_q <= '0;
						state_q <= S_DIV;
					end else begin
						state_q <= S_ROOTW;
					end
				end
				S_ROOTW: begin
					steps_q <= '0;
					idx_q <= root_rd;
					if ({1'b0, root_rd} >= nodes_q) begin
						err_q <= ST_ROOT;
						state_q <= S_ERR;
					end else begin
						state_q <= S_NODE;
					end
				end
				S_NODE: begin
					node_q <= node_rd;
					if (steps_q == nodes_q) begin
						err_q <= ST_LOOP;
						state_q <= S_ERR;
					end else if (node_rd.leaf) begin
						if ({1'b0, node_rd.cls} >= classes_q) begin
							err_q <= ST_CLASS;
							state_q <= S_ERR;
						end else begin
							votes_q[node_rd.cls] <= votes_q[node_rd.cls] + 7'd1;
							tree_q <= tree_q + 7'd1;
							state_q <= S_ROOT;
						end
					end else if ({1'b0, node_rd.feat} >= feats_q) begin
						err_q <= ST_FEAT;
						state_q <= S_ERR;
					end else begin
						state_q <= S_FEAT;
					end
				end
				S_FEAT: state_q <= S_CMP;
				S_CMP: begin
					if ({1'b0, next_idx} >= nodes_q) begin
						err_q <= ST_CHILD;
						state_q <= S_ERR;
					end else begin
						idx_q <= next_idx;
						steps_q <= steps_q + 11'd1;
						state_q <= S_NODE;
					end
				end
				S_DIV: begin
					// restoring divide of (votes*65536 + trees/2) by trees, one bit per cycle
					if (bit_q == 5'd0) begin
						dvd_q <= {votes_q[cls_q], 16'd0} + {17'd0, trees_q[6:1]};
						rem_q <= '0;
						quo_q <= '0;
						bit_q <= 5'd1;
					end else if (bit_q != 5'd24) begin
						dvd_q <= {dvd_q[21:0], 1'b0};
						if (rem_sh >= {1'b0, trees_q}) begin
							rem_q <= 7'(rem_sh - {1'b0, trees_q});
							quo_q <= {quo_q[15:0], 1'b1};
						end else begin
							rem_q <= rem_sh[6:0];
							quo_q <= {quo_q[15:0], 1'b0};
						end
						bit_q <= bit_q + 5'd1;
					end else begin
						res_valid <= 1'b1;
						class_index <= 4'(cls_q);
						vote_count <= votes_q[cls_q];
						score_q16 <= quo_q;
						status <= ST_OK;
						last <= ({1'b0, cls_q} + 5'd1 == classes_q);
						if ({1'b0, cls_q} + 5'd1 == classes_q) begin
							state_q <= S_IDLE;
						end else begin
							cls_q <= cls_q + 1'b1;
							bit_q <= '0;
						end
					end
				end
				S_ERR: begin
					res_valid <= 1'b1;
					class_index <= '0;
					vote_count <= '0;
					score_q16 <= '0;
					status <= err_q;
					last <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_busy_run: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && req_type == REQ_RUN) |=> busy)
		else $error("run not started");
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && status != ST_OK) |-> (last && vote_count == '0))
		else $error("error result malformed");
	a_score_max: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> score_q16 <= 17'd65536)
		else $error("score above one");
endmodule
`default_nettype wire
